FILE: src/lz77tc_pkg.sv
// Package: sizes, types and state encoding for the LZ77 token compressor.
`default_nettype none
package lz77tc_pkg;
  localparam int WindowSize    = 1024;
  localparam int LookaheadSize = 16;
  localparam int HAW = $clog2(WindowSize);       // history address width
  localparam int HFW = $clog2(WindowSize + 1);   // history fill width
  localparam int LAW = $clog2(LookaheadSize);    // lookahead index width
  localparam int LFW = $clog2(LookaheadSize + 1);
  localparam int MMW = 5;
  localparam logic [MMW-1:0] MinMatchReset = MMW'(3);

  localparam logic TokLiteral = 1'b0;
  localparam logic TokMatch   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_MOVE,
    ST_DONE
  } lz_state_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   lit;
    logic [10:0]  distance;
    logic [4:0]   len;
    logic         last;
  } token_t;
endpackage
`default_nettype wire

FILE: src/lz77tc_hist_ram.sv
// History window memory: one write port, one registered read port.
`default_nettype none
module lz77tc_hist_ram #(
  parameter int Depth = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/lz77_token_compressor_core.sv
// Top level: LZ77 token compressor with a serial history search.
// Usage:
//  Bytes enter on the in_ stream (tdata = in_byte, tlast = in_last). Each word
//  that brings the lookahead to sixteen bytes produces one token; a word with
//  tlast produces tokens until the lookahead is empty, then the history is
//  cleared so the next stream starts fresh. Tokens leave on the out_ stream
//  (tuser = token_kind), tlast marking the last token caused by one input word.
//  A word without a token passes through ST_IDLE and ST_DONE. A token starts in
//  ST_DONE with a search over up to history_fill + 1 start positions; each
//  position issues an address and then compares up to 16 bytes, and the search
//  ends early at a full-length match. ST_EMIT loads the output register, then
//  ST_MOVE moves each consumed byte into the history. While out_ holds tready
//  low the token waits in the single output register; the next token's search
//  may run, but it waits before loading, so no token is lost. Reset empties the
//  history and lookahead and sets min_match to 3; cfg_wr writes min_match, which
//  the user must do only when idle; the block does not enforce this.
`default_nettype none
module lz77_token_compressor_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr,
  input  wire logic [4:0]  cfg_wdata,     // min_match
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] in_byte
  input  wire logic        in_tlast,      // in_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,     // [7:0] literal, [18:8] distance,
                                          // [23:19] match_length
  output logic             out_tuser,     // token_kind
  output logic             out_tlast      // token_last
);
  import lz77tc_pkg::*;

  lz_state_t state_r, state_nxt;
  logic [MMW-1:0] min_match_r;
  logic [7:0]     la_r [LookaheadSize];
  logic [LFW-1:0] la_fill_r, la_fill_nxt;
  logic [HFW-1:0] hfill_r, hfill_nxt;
  logic [HAW-1:0] hhead_r, hhead_nxt;
  logic           flush_r, flush_nxt;
  // search registers
  logic [HFW-1:0] n_r, n_nxt;
  logic [LFW-1:0] k_r, k_nxt;
  logic [LFW-1:0] best_r, best_nxt;
  logic [HFW-1:0] pos_r, pos_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic [LFW-1:0] cons_r, cons_nxt;
  token_t         tok_r, tok_nxt;
  logic           ovalid_r, ovalid_nxt;

  logic           we;
  logic [HAW-1:0] waddr, raddr;
  logic [7:0]     wdata, rdata;
  logic           shift_one, push_byte;

  lz77tc_hist_ram #(.Depth(WindowSize), .AW(HAW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [HFW-1:0] nk, rd_idx;
  assign nk = n_r + HFW'(k_r);
  // read the byte compared next cycle: history index n_nxt + k_nxt
  assign rd_idx = n_nxt + HFW'(k_nxt);
  // physical address of a history index (oldest at index 0)
  assign raddr = HAW'(hhead_r - HAW'(hfill_r) + HAW'(rd_idx));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {tok_r.len, tok_r.distance, tok_r.lit};
  assign out_tuser  = tok_r.kind;
  assign out_tlast  = tok_r.last;
  assign we    = (state_r == ST_MOVE);
  assign waddr = hhead_r;
  assign wdata = la_r[0];

  // next state
  always_comb begin
    state_nxt   = state_r;
    la_fill_nxt = la_fill_r;
    hfill_nxt   = hfill_r;
    hhead_nxt   = hhead_r;
    flush_nxt   = flush_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    best_nxt    = best_r;
    pos_nxt     = pos_r;
    rd_pend_nxt = 1'b0;
    cons_nxt    = cons_r;
    tok_nxt     = tok_r;
    ovalid_nxt  = ovalid_r;
    shift_one   = 1'b0;
    push_byte   = 1'b0;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          push_byte = (la_fill_r < LFW'(LookaheadSize));
          flush_nxt = in_tlast;
          if (push_byte) begin
            la_fill_nxt = la_fill_r + LFW'(1);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (la_fill_r != '0 && (flush_r || la_fill_r == LFW'(LookaheadSize))) begin
          n_nxt = hfill_r; k_nxt = '0; best_nxt = '0; pos_nxt = '0;
          state_nxt = ST_SEARCH;
        end else begin
          if (flush_r) begin
            hfill_nxt = '0; hhead_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (rd_pend_r) begin
          // compare one byte
          if (rdata == la_r[k_r[LAW-1:0]]) begin
            k_nxt = k_r + LFW'(1);
          end else begin
            rd_pend_nxt = 1'b0;
            if (k_r > best_r) begin best_nxt = k_r; pos_nxt = n_r; end
            if (k_r > best_r && k_r == la_fill_r) state_nxt = ST_EMIT;
            else if (n_r == '0) state_nxt = ST_EMIT;
            else begin n_nxt = n_r - HFW'(1); k_nxt = '0; end
          end
        end
        if (!rd_pend_r || (rd_pend_r && rdata == la_r[k_r[LAW-1:0]])) begin
          // next compare address or finish this start position
          if (k_nxt < la_fill_r && nk + HFW'(rd_pend_r) < hfill_r) begin
            rd_pend_nxt = 1'b1;
          end else begin
            if (k_nxt > best_r) begin best_nxt = k_nxt; pos_nxt = n_r; end
            if (best_nxt == la_fill_r || n_r == '0) state_nxt = ST_EMIT;
            else begin n_nxt = n_r - HFW'(1); k_nxt = '0; end
          end
        end
      end
      ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          if (best_r == '0 || MMW'(best_r) < min_match_r) begin
            tok_nxt = '{kind: TokLiteral, lit: la_r[0], distance: '0, len: '0, last: 1'b0};
            cons_nxt = LFW'(1);
          end else begin
            tok_nxt = '{kind: TokMatch, lit: '0, distance: 11'(hfill_r - pos_r),
                        len: 5'(best_r), last: 1'b0};
            cons_nxt = best_r;
          end
          tok_nxt.last = !flush_r || (la_fill_r == cons_nxt);
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        shift_one   = 1'b1;
        la_fill_nxt = la_fill_r - LFW'(1);
        hhead_nxt   = hhead_r + HAW'(1);
        if (hfill_r < HFW'(WindowSize)) hfill_nxt = hfill_r + HFW'(1);
        cons_nxt = cons_r - LFW'(1);
        if (cons_r == LFW'(1)) begin
          state_nxt = flush_r ? ST_DONE : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; min_match_r <= MinMatchReset;
      la_fill_r <= '0; hfill_r <= '0; hhead_r <= '0; flush_r <= 1'b0;
      ovalid_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) min_match_r <= cfg_wdata;
      la_fill_r <= la_fill_nxt; hfill_r <= hfill_nxt; hhead_r <= hhead_nxt;
      flush_r <= flush_nxt; ovalid_r <= ovalid_nxt; rd_pend_r <= rd_pend_nxt;
    end
  end

  // datapath registers; shift the lookahead one byte per consumed byte
  always_ff @(posedge clk) begin
    n_r <= n_nxt; k_r <= k_nxt; best_r <= best_nxt; pos_r <= pos_nxt;
    cons_r <= cons_nxt; tok_r <= tok_nxt;
    if (shift_one) begin
      for (int i = 0; i < LookaheadSize - 1; i++) la_r[i] <= la_r[i+1];
    end else if (push_byte) begin
      la_r[la_fill_r[LAW-1:0]] <= in_tdata;
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the LZ77 token compressor: stream stimulus, token prediction and checks.
module tb_top;
  import lz77tc_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;       // [7:0] in_byte
  logic        in_tlast = 1'b0;     // in_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [7:0] literal, [18:8] distance, [23:19] length
  logic        out_tuser;           // token_kind
  logic        out_tlast;           // token_last
  logic        in_taken = 1'b0;

  lz77_token_compressor_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_wr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_word_t;

  // Predictor state
  logic [7:0]  hist_mem [WindowSize];
  int unsigned hist_fill, hist_head;
  logic [7:0]  la_buf [LookaheadSize];
  int unsigned la_fill;
  logic [4:0]  min_len;

  byte_word_t  pending_bytes[$];
  token_t      expected_tokens[$];
  int          errors = 0;
  int          tokens_seen = 0, matches_seen = 0, words_sent = 0;
  longint      cycles = 0;

  function automatic logic [7:0] hist_byte(int unsigned j);
    return hist_mem[(hist_head + WindowSize - hist_fill + j) % WindowSize];
  endfunction

  // Move n lookahead bytes into the history.
  function automatic void shift_to_history(int unsigned n);
    if (n > la_fill) n = la_fill;
    for (int unsigned j = 0; j < n; j++) begin
      hist_mem[hist_head] = la_buf[j];
      hist_head = (hist_head + 1) % WindowSize;
      if (hist_fill < WindowSize) hist_fill++;
    end
    for (int unsigned j = 0; j + n < la_fill; j++) la_buf[j] = la_buf[j + n];
    la_fill -= n;
  endfunction

  function automatic token_t search_token();
    token_t t;
    int unsigned best, pos, k;
    int n;
    best = 0;
    pos = 0;
    t = '0;
    for (n = hist_fill; n >= 0; n--) begin
      k = 0;
      while (k < la_fill && n + k < hist_fill && hist_byte(n + k) == la_buf[k]) k++;
      if (k > best) begin
        best = k;
        pos = n;
      end
      if (best == la_fill) break;
    end
    if (best == 0 || best < min_len) begin
      t.kind = TokLiteral;
      t.lit = la_buf[0];
      shift_to_history(1);
    end else begin
      t.kind = TokMatch;
      t.distance = 11'(hist_fill - pos);
      t.len = 5'(best);
      shift_to_history(best);
    end
    return t;
  endfunction

  function automatic void predict_tokens(byte_word_t w);
    token_t toks[$];
    if (la_fill < LookaheadSize) begin
      la_buf[la_fill] = w.data;
      la_fill++;
    end
    if (w.last) begin
      while (la_fill > 0) toks.push_back(search_token());
      hist_fill = 0;
      hist_head = 0;
    end else if (la_fill >= LookaheadSize) begin
      toks.push_back(search_token());
    end
    if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
    foreach (toks[i]) expected_tokens.push_back(toks[i]);
  endfunction

  // Note an accepted input word at the rising edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Driver: bursts with random gaps.
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_tokens(pending_bytes.pop_front());
        words_sent++;
      end
      if (in_tvalid && !in_taken) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
        end else begin
          burst_left--;
          in_tvalid <= 1'b1;
          in_tdata <= pending_bytes[0].data;
          in_tlast <= pending_bytes[0].last;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
      // receiver stall pattern: long ready stretches and random stall runs
      out_tready <= (cycles % 512 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each token with the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      tokens_seen++;
      if (out_tuser) matches_seen++;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token %h kind %b last %b",
                                   out_tdata, out_tuser, out_tlast);
      end else begin
        token_t e;
        e = expected_tokens.pop_front();
        if (out_tuser !== e.kind || out_tdata[7:0] !== e.lit ||
            out_tdata[18:8] !== e.distance || out_tdata[23:19] !== e.len ||
            out_tlast !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("token mismatch: exp kind %b lit %h dist %0d len %0d last %b, %s %b %h %0d %0d %b",
                     e.kind, e.lit, e.distance, e.len, e.last, "got kind/lit/dist/len/last",
                     out_tuser, out_tdata[7:0], out_tdata[18:8], out_tdata[23:19], out_tlast);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Queue a stream of n bytes, ending in tlast; mode picks the content style.
  task automatic add_stream(int n, int mode);
    byte_word_t w;
    logic [7:0] motif [8];
    int plen;
    plen = $urandom_range(1, 8);
    foreach (motif[i]) motif[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w.data = 8'($urandom_range(0, 255));
        1: w.data = motif[i % plen];
        default: w.data = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : motif[$urandom_range(0, plen - 1)];
      endcase
      w.last = (i == n - 1);
      pending_bytes.push_back(w);
    end
  endtask

  task automatic drain_and_set(logic [4:0] v);
    while (pending_bytes.size() > 0 || in_tvalid || expected_tokens.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_wr <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr <= 1'b0;
    min_len = v;
  endtask

  initial begin
    byte_word_t w;
    hist_fill = 0;
    hist_head = 0;
    la_fill = 0;
    min_len = MinMatchReset;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single byte stream, extremes, lookahead overflow, repeats.
    w.data = 8'h00; w.last = 1'b1; pending_bytes.push_back(w);
    for (int i = 0; i < 20; i++) begin
      w.data = (i % 2) ? 8'hFF : 8'h00;
      w.last = (i == 19);
      pending_bytes.push_back(w);
    end
    drain_and_set(5'd0);
    add_stream(24, 1);
    drain_and_set(5'd16);
    add_stream(24, 1);
    drain_and_set(5'd31);
    add_stream(24, 1);
    drain_and_set(5'd1);
    add_stream(30, 2);

    // Random streams under several min_match settings.
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set(ph == 3 ? 5'd3 : 5'($urandom_range(0, 18)));
      for (int s = 0; s < 3; s++) add_stream($urandom_range(1, 40), $urandom_range(0, 2));
    end
    // One longer stream with many lookahead refills.
    drain_and_set(5'd2);
    add_stream(50, 2);

    while (pending_bytes.size() > 0 || in_tvalid || expected_tokens.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d bytes, checked %0d tokens (%0d matches).",
             words_sent, tokens_seen, matches_seen);
    $display("min_match settings covered 0, 1, 2, 3, 16, 31 and random values.");
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/lz77tc_pkg.sv
src/lz77tc_hist_ram.sv
src/lz77_token_compressor_core.sv
tb/tb_top.sv
